### hdl/dfa_mealy_transducer_defines.svh
// Assertion macros shared by the automaton RTL.
// No dependencies; sampled on clock, disabled while reset is high.
`ifndef DFA_MEALY_TRANSDUCER_DEFINES_SVH
`define DFA_MEALY_TRANSDUCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DMT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define DMT_IMPLY_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DMT_IMPLY(label, ante, cons, msg)
`define DMT_IMPLY_NEXT(label, ante, cons, msg)
`endif

`endif

### hdl/dmt_pkg.sv
// Shared types and constants for the table-driven Mealy automaton.
// No dependencies.
package dmt_pkg;

   localparam int SYMBOL_BITS  = 8;
   localparam int COL_BITS     = 4;
   localparam int STATE_BITS   = 4;
   localparam int OUT_BITS     = 8;
   localparam int MAP_DEPTH    = 2 ** SYMBOL_BITS;
   localparam int EDGE_BITS    = STATE_BITS + OUT_BITS;
   localparam int DEF_MAX_STATES  = 16;
   localparam int DEF_MAX_SYMBOLS = 16;

   typedef enum logic [1:0] {
      REQ_MAP    = 2'd0,
      REQ_EDGE   = 2'd1,
      REQ_ACCEPT = 2'd2,
      REQ_RUN    = 2'd3
   } req_code_type;

   typedef struct packed {
      logic load;
      logic run_start;
      logic edge_rd;
      logic finish;
   } dmt_cmd_type;

endpackage

### hdl/dmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/dmt_ctrl.sv
// Sequencer for the automaton: handshakes, run phases and result valid.
// Depends on dmt_pkg and the assertion macro header.
`include "dfa_mealy_transducer_defines.svh"
module dmt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dmt_pkg::dmt_cmd_type cmd
);
   import dmt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_EDGE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;
   logic      run;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_EDGE) && out_free);
   assign accept    = req_valid && req_ready;
   assign run       = accept && (req_code_type'(req_type) == REQ_RUN);

   assign cmd.load      = accept && !run;
   assign cmd.run_start = run;
   assign cmd.edge_rd   = (state_ff == ST_MAP);
   assign cmd.finish    = (state_ff == ST_EDGE) && out_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (run) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = run ? ST_MAP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `DMT_IMPLY_NEXT(a_map_then_edge, state_ff == ST_MAP, state_ff == ST_EDGE, "map phase not followed by edge phase")
   `DMT_IMPLY_NEXT(a_finish_valid, cmd.finish, rsp_valid_ff, "finished word has no result")
   `DMT_IMPLY(a_no_accept_in_map, state_ff == ST_MAP, !req_ready, "word accepted during map phase")

endmodule

### hdl/dmt_dp.sv
// Datapath: symbol map, edge table, accepting flags, run state and result register.
// Depends on dmt_pkg, dmt_ram and the assertion macro header.
`include "dfa_mealy_transducer_defines.svh"
module dmt_dp #(
   parameter int MAX_STATES  = dmt_pkg::DEF_MAX_STATES,
   parameter int MAX_SYMBOLS = dmt_pkg::DEF_MAX_SYMBOLS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dmt_pkg::dmt_cmd_type              cmd,
   input  logic [1:0]                       req_type,
   input  logic [dmt_pkg::SYMBOL_BITS-1:0]  req_symbol,
   input  logic [dmt_pkg::COL_BITS-1:0]     req_column,
   input  logic [dmt_pkg::STATE_BITS-1:0]   req_row_state,
   input  logic [dmt_pkg::STATE_BITS-1:0]   req_next_state,
   input  logic [dmt_pkg::OUT_BITS-1:0]     req_edge_output,
   input  logic                             req_accept_bit,
   input  logic                             req_word_end,
   input  logic                             cfg_wr,
   input  logic [dmt_pkg::STATE_BITS-1:0]   cfg_wdata,
   output logic [dmt_pkg::STATE_BITS-1:0]   start_state,
   output logic [dmt_pkg::OUT_BITS-1:0]     rsp_out_symbol,
   output logic                             rsp_bad_symbol,
   output logic                             rsp_word_done,
   output logic                             rsp_accepted
);
   import dmt_pkg::*;

   localparam int EDGE_DEPTH = MAX_STATES * MAX_SYMBOLS;
   localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
   localparam int MAP_AW     = $clog2(MAP_DEPTH);

   req_code_type code;
   logic col_ok, row_ok, nxt_ok;
   logic map_we, edge_we, acc_we;

   logic [MAP_DEPTH-1:0]  map_valid_ff, map_valid_in;
   logic [MAX_STATES-1:0] acc_ff, acc_in;
   logic [COL_BITS-1:0]   map_rdata;
   logic [EDGE_BITS-1:0]  edge_rdata;
   logic [EDGE_AW-1:0]    edge_waddr, edge_raddr;

   logic                  hit_ff;
   logic                  word_end_ff;
   logic [STATE_BITS-1:0] state_ff, state_in;
   logic                  word_bad_ff, word_bad_in;
   logic [STATE_BITS-1:0] start_ff;

   logic [OUT_BITS-1:0]   out_symbol_ff;
   logic                  bad_symbol_ff, word_done_ff, accepted_ff;

   logic                  bad_now, st_ok, take, nst_ok, acc_rd;
   logic [OUT_BITS-1:0]   osym;
   logic [STATE_BITS-1:0] nstate;

   assign code    = req_code_type'(req_type);
   assign col_ok  = 32'(req_column) < MAX_SYMBOLS;
   assign row_ok  = 32'(req_row_state) < MAX_STATES;
   assign nxt_ok  = 32'(req_next_state) < MAX_STATES;
   assign map_we  = cmd.load && (code == REQ_MAP) && col_ok;
   assign edge_we = cmd.load && (code == REQ_EDGE) && col_ok && row_ok && nxt_ok;
   assign acc_we  = cmd.load && (code == REQ_ACCEPT) && row_ok;

   assign edge_waddr = EDGE_AW'(32'(req_row_state) * MAX_SYMBOLS + 32'(req_column));
   assign edge_raddr = EDGE_AW'(32'(state_ff) * MAX_SYMBOLS + 32'(map_rdata));

   dmt_ram #(
      .WIDTH (COL_BITS),
      .DEPTH (MAP_DEPTH)
   ) u_map_ram (
      .clock (clock),
      .we    (map_we),
      .waddr (MAP_AW'(req_symbol)),
      .wdata (req_column),
      .re    (cmd.run_start),
      .raddr (MAP_AW'(req_symbol)),
      .rdata (map_rdata)
   );

   dmt_ram #(
      .WIDTH (EDGE_BITS),
      .DEPTH (EDGE_DEPTH)
   ) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata ({req_next_state, req_edge_output}),
      .re    (cmd.edge_rd),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   always_comb begin
      map_valid_in = map_valid_ff;
      if (map_we) begin
         map_valid_in[req_symbol] = 1'b1;
      end
      acc_in = acc_ff;
      for (int i = 0; i < MAX_STATES; i++) begin
         if (acc_we && (32'(req_row_state) == i)) begin
            acc_in[i] = req_accept_bit;
         end
      end
   end

   // run step, evaluated in the edge phase
   always_comb begin
      bad_now = word_bad_ff || !hit_ff;
      st_ok   = 32'(state_ff) < MAX_STATES;
      take    = !bad_now && st_ok;
      osym    = take ? edge_rdata[OUT_BITS-1:0] : '0;
      nstate  = take ? edge_rdata[EDGE_BITS-1:OUT_BITS] : state_ff;
      nst_ok  = 32'(nstate) < MAX_STATES;
      acc_rd  = 1'b0;
      for (int i = 0; i < MAX_STATES; i++) begin
         if (32'(nstate) == i) begin
            acc_rd = acc_ff[i];
         end
      end
      state_in    = state_ff;
      word_bad_in = word_bad_ff;
      if (cmd.finish) begin
         if (word_end_ff) begin
            state_in    = start_ff;
            word_bad_in = 1'b0;
         end else begin
            state_in    = nstate;
            word_bad_in = bad_now;
         end
      end
      if (cfg_wr) begin
         state_in    = cfg_wdata;
         word_bad_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
         acc_ff       <= '0;
         state_ff     <= '0;
         word_bad_ff  <= 1'b0;
         start_ff     <= '0;
      end else begin
         map_valid_ff <= map_valid_in;
         acc_ff       <= acc_in;
         state_ff     <= state_in;
         word_bad_ff  <= word_bad_in;
         if (cfg_wr) begin
            start_ff <= cfg_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.run_start) begin
         hit_ff      <= map_valid_ff[req_symbol];
         word_end_ff <= req_word_end;
      end
      if (cmd.finish) begin
         out_symbol_ff <= osym;
         bad_symbol_ff <= bad_now;
         word_done_ff  <= word_end_ff;
         accepted_ff   <= word_end_ff && !bad_now && nst_ok && acc_rd;
      end
   end

   assign start_state    = start_ff;
   assign rsp_out_symbol = out_symbol_ff;
   assign rsp_bad_symbol = bad_symbol_ff;
   assign rsp_word_done  = word_done_ff;
   assign rsp_accepted   = accepted_ff;

   `DMT_IMPLY_NEXT(a_word_end_restarts, cmd.finish && word_end_ff, !word_bad_ff && (state_ff == start_ff), "word end did not return to start state")
   `DMT_IMPLY_NEXT(a_cfg_restarts, cfg_wr, (state_ff == start_ff) && !word_bad_ff, "start state write not applied")

endmodule

### hdl/dfa_mealy_transducer.sv
// Run word: symbol-map read, then edge-table read, then result register. A new run
// word is taken no earlier than the edge phase of the last, bound by the state feeding
// back through the registered edge-table read; table load words write on acceptance.
// Reset (synchronous): symbol map entries invalid, accepting flags and start state
// cleared, state to 0; the edge table holds no defined contents until written.
// Top level; depends on dmt_pkg, dmt_ctrl, dmt_dp and dmt_ram.
module dfa_mealy_transducer #(
   parameter int MAX_STATES  = dmt_pkg::DEF_MAX_STATES,
   parameter int MAX_SYMBOLS = dmt_pkg::DEF_MAX_SYMBOLS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_type,
   input  logic [dmt_pkg::SYMBOL_BITS-1:0]  req_symbol,
   input  logic [dmt_pkg::COL_BITS-1:0]     req_column,
   input  logic [dmt_pkg::STATE_BITS-1:0]   req_row_state,
   input  logic [dmt_pkg::STATE_BITS-1:0]   req_next_state,
   input  logic [dmt_pkg::OUT_BITS-1:0]     req_edge_output,
   input  logic                             req_accept_bit,
   input  logic                             req_word_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [dmt_pkg::OUT_BITS-1:0]     rsp_out_symbol,
   output logic                             rsp_bad_symbol,
   output logic                             rsp_word_done,
   output logic                             rsp_accepted,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [2:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import dmt_pkg::*;

   dmt_cmd_type           cmd;
   logic                  cfg_wr;
   logic                  reg_hit;
   logic [STATE_BITS-1:0] start_state;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == 1'b0);
   assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
   assign prdata  = reg_hit ? 32'(start_state) : '0;

   dmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dmt_dp #(
      .MAX_STATES  (MAX_STATES),
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_type        (req_type),
      .req_symbol      (req_symbol),
      .req_column      (req_column),
      .req_row_state   (req_row_state),
      .req_next_state  (req_next_state),
      .req_edge_output (req_edge_output),
      .req_accept_bit  (req_accept_bit),
      .req_word_end    (req_word_end),
      .cfg_wr          (cfg_wr),
      .cfg_wdata       (pwdata[STATE_BITS-1:0]),
      .start_state     (start_state),
      .rsp_out_symbol  (rsp_out_symbol),
      .rsp_bad_symbol  (rsp_bad_symbol),
      .rsp_word_done   (rsp_word_done),
      .rsp_accepted    (rsp_accepted)
   );

endmodule

### verif/tb_dfa_mealy_transducer.sv
// Self-checking testbench for dfa_mealy_transducer: directed table, then random table loads and
// words under random idling, checked against an in-bench automaton predictor.
// Depends on dmt_pkg and the dfa_mealy_transducer RTL.
`timescale 1ns / 1ps

module tb_dfa_mealy_transducer;
   import dmt_pkg::*;

   typedef struct packed {
      req_code_type kind;
      logic [7:0]   sym;
      logic [3:0]   col;
      logic [3:0]   row;
      logic [3:0]   nxt;
      logic [7:0]   eout;
      logic         abit;
      logic         wend;
   } dfa_word_type;

   typedef struct packed {
      logic [7:0] out_sym;
      logic       bad;
      logic       done;
      logic       acc;
   } translation_type;

   typedef struct packed {
      logic            cfg_before;
      logic [3:0]      cfg_val;
      dfa_word_type    w;
      logic            typed;
      translation_type exp;
   } script_row_type;

   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_type = '0;
   logic [7:0] req_symbol = '0;
   logic [3:0] req_column = '0;
   logic [3:0] req_row_state = '0;
   logic [3:0] req_next_state = '0;
   logic [7:0] req_edge_output = '0;
   logic req_accept_bit = 1'b0;
   logic req_word_end = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_symbol;
   logic rsp_bad_symbol;
   logic rsp_word_done;
   logic rsp_accepted;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // automaton predictor state
   logic       map_valid [256];
   logic [3:0] map_col [256];
   logic [3:0] edge_next [256];
   logic [7:0] edge_out [256];
   logic       acc_flag [16];
   logic [3:0] cur_state;
   logic [3:0] start_state_q;
   logic       word_bad;
   logic [7:0] mapped_syms [$];

   translation_type pending_translations [$];
   translation_type want;
   int unsigned mismatch_count = 0;
   bit calm = 1'b0;
   bit hold_req = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   script_row_type script [25];

   dfa_mealy_transducer uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_symbol(req_symbol), .req_column(req_column), .req_row_state(req_row_state),
      .req_next_state(req_next_state), .req_edge_output(req_edge_output),
      .req_accept_bit(req_accept_bit), .req_word_end(req_word_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_symbol(rsp_out_symbol),
      .rsp_bad_symbol(rsp_bad_symbol), .rsp_word_done(rsp_word_done),
      .rsp_accepted(rsp_accepted),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit advance_automaton(input dfa_word_type w, output translation_type t);
      logic [7:0] idx;
      t = '0;
      case (w.kind)
         REQ_MAP: begin
            if (!map_valid[w.sym]) mapped_syms.push_back(w.sym);
            map_valid[w.sym] = 1'b1;
            map_col[w.sym] = w.col;
            return 1'b0;
         end
         REQ_EDGE: begin
            edge_next[{w.row, w.col}] = w.nxt;
            edge_out[{w.row, w.col}] = w.eout;
            return 1'b0;
         end
         REQ_ACCEPT: begin
            acc_flag[w.row] = w.abit;
            return 1'b0;
         end
         default: begin
            if (!map_valid[w.sym]) begin
               word_bad = 1'b1;
            end else if (!word_bad) begin
               idx = {cur_state, map_col[w.sym]};
               t.out_sym = edge_out[idx];
               cur_state = edge_next[idx];
            end
            t.bad = word_bad;
            t.done = w.wend;
            if (w.wend) begin
               t.acc = !word_bad && acc_flag[cur_state];
               cur_state = start_state_q;
               word_bad = 1'b0;
            end
            return 1'b1;
         end
      endcase
   endfunction

   function automatic dfa_word_type random_word();
      dfa_word_type w;
      int pick;
      w.sym  = 8'($urandom_range(0, 255));
      w.col  = 4'($urandom_range(0, 15));
      w.row  = 4'($urandom_range(0, 15));
      w.nxt  = 4'($urandom_range(0, 15));
      w.eout = 8'($urandom_range(0, 255));
      w.abit = 1'($urandom_range(0, 1));
      w.wend = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         w.kind = REQ_RUN;
         w.wend = ($urandom_range(0, 3) == 0);
         if (mapped_syms.size() != 0 && $urandom_range(0, 99) < 88)
            w.sym = mapped_syms[$urandom_range(0, mapped_syms.size() - 1)];
      end else if (pick < 80) begin
         w.kind = REQ_MAP;
      end else if (pick < 90) begin
         w.kind = REQ_EDGE;
      end else begin
         w.kind = REQ_ACCEPT;
      end
      return w;
   endfunction

   // called and returns at a falling edge
   task automatic send_word(input dfa_word_type w, input bit typed,
                            input translation_type typed_exp);
      translation_type t;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= w.kind;
      req_symbol <= w.sym;
      req_column <= w.col;
      req_row_state <= w.row;
      req_next_state <= w.nxt;
      req_edge_output <= w.eout;
      req_accept_bit <= w.abit;
      req_word_end <= w.wend;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (advance_automaton(w, t))
         pending_translations.push_back(typed ? typed_exp : t);
      @(negedge clock);
   endtask

   // called and returns at a falling edge; waits for the block to drain first
   task automatic load_start_state(input logic [3:0] v);
      req_valid <= 1'b0;
      while (pending_translations.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= '0;
      pwdata <= {28'd0, v};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      start_state_q = v;
      cur_state = v;
      word_bad = 1'b0;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {28'd0, v}) begin
         $error("start_state expected %0h actual %0h", v, prdata);
         mismatch_count++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // result side: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_translations.size() == 0) begin
            $error("result with no word outstanding: out_symbol %0h", rsp_out_symbol);
            mismatch_count++;
         end else begin
            want = pending_translations.pop_front();
            if (rsp_out_symbol !== want.out_sym) begin
               $error("out_symbol expected %0h actual %0h", want.out_sym, rsp_out_symbol);
               mismatch_count++;
            end
            if (rsp_bad_symbol !== want.bad) begin
               $error("bad_symbol expected %0h actual %0h", want.bad, rsp_bad_symbol);
               mismatch_count++;
            end
            if (rsp_word_done !== want.done) begin
               $error("word_done expected %0h actual %0h", want.done, rsp_word_done);
               mismatch_count++;
            end
            if (rsp_accepted !== want.acc) begin
               $error("accepted expected %0h actual %0h", want.acc, rsp_accepted);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      dfa_word_type fill;
      translation_type none;
      none = '0;
      for (int i = 0; i < 256; i++) begin
         map_valid[i] = 1'b0;
         map_col[i] = '0;
         edge_next[i] = '0;
         edge_out[i] = '0;
      end
      for (int i = 0; i < 16; i++) acc_flag[i] = 1'b0;
      cur_state = '0;
      start_state_q = '0;
      word_bad = 1'b0;

      //            cfg  val    kind        sym    col    row    nxt    eout   ab    we
      script[0]  = '{1'b0, 4'd0, '{REQ_RUN,    8'h00, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b1},
                    1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}};
      script[1]  = '{1'b0, 4'd0, '{REQ_RUN,    8'hFF, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
                    1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}};
      script[2]  = '{1'b0, 4'd0, '{REQ_MAP,    8'hFF, 4'd15, 4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
                    1'b0, '0};
      // mapped byte inside a word already gone bad
      script[3]  = '{1'b0, 4'd0, '{REQ_RUN,    8'hFF, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b1},
                    1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}};
      script[4]  = '{1'b0, 4'd0, '{REQ_MAP,    8'h00, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
                    1'b0, '0};
      script[5]  = '{1'b0, 4'd0, '{REQ_EDGE,   8'h00, 4'd0,  4'd0,  4'd15, 8'hFF, 1'b0, 1'b0},
                    1'b0, '0};
      script[6]  = '{1'b0, 4'd0, '{REQ_EDGE,   8'h00, 4'd15, 4'd15, 4'd0,  8'h00, 1'b0, 1'b0},
                    1'b0, '0};
      script[7]  = '{1'b0, 4'd0, '{REQ_EDGE,   8'h00, 4'd0,  4'd15, 4'd15, 8'hA5, 1'b0, 1'b0},
                    1'b0, '0};
      script[8]  = '{1'b0, 4'd0, '{REQ_EDGE,   8'h00, 4'd15, 4'd0,  4'd0,  8'h5A, 1'b0, 1'b0},
                    1'b0, '0};
      script[9]  = '{1'b0, 4'd0, '{REQ_ACCEPT, 8'h00, 4'd0,  4'd15, 4'd0,  8'h00, 1'b1, 1'b0},
                    1'b0, '0};
      script[10] = '{1'b0, 4'd0, '{REQ_RUN,    8'h00, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b1},
                    1'b1, '{8'hFF, 1'b0, 1'b1, 1'b1}};
      script[11] = '{1'b0, 4'd0, '{REQ_RUN,    8'h00, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
                    1'b0, '0};
      script[12] = '{1'b0, 4'd0, '{REQ_ACCEPT, 8'h00, 4'd0,  4'd0,  4'd0,  8'h00, 1'b1, 1'b0},
                    1'b0, '0};
      // word ends back in the start state, now accepting
      script[13] = '{1'b0, 4'd0, '{REQ_RUN,    8'hFF, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b1},
                    1'b0, '0};
      script[14] = '{1'b0, 4'd0, '{REQ_ACCEPT, 8'h00, 4'd0,  4'd15, 4'd0,  8'h00, 1'b0, 1'b0},
                    1'b0, '0};
      script[15] = '{1'b0, 4'd0, '{REQ_RUN,    8'h00, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
                    1'b0, '0};
      script[16] = '{1'b0, 4'd0, '{REQ_RUN,    8'h00, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b1},
                    1'b0, '0};
      // remap a byte to another column
      script[17] = '{1'b0, 4'd0, '{REQ_MAP,    8'hFF, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
                    1'b0, '0};
      script[18] = '{1'b0, 4'd0, '{REQ_RUN,    8'hFF, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
                    1'b0, '0};
      // start state rewritten mid-word
      script[19] = '{1'b1, 4'd15, '{REQ_RUN,   8'h00, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b1},
                    1'b0, '0};
      script[20] = '{1'b0, 4'd0, '{REQ_RUN,    8'h80, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b0},
                    1'b0, '0};
      script[21] = '{1'b0, 4'd0, '{REQ_RUN,    8'h00, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b1},
                    1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}};
      script[22] = '{1'b1, 4'd0, '{REQ_RUN,    8'h00, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b1},
                    1'b0, '0};
      script[23] = '{1'b0, 4'd0, '{REQ_ACCEPT, 8'h00, 4'd0,  4'd15, 4'd0,  8'h00, 1'b1, 1'b0},
                    1'b0, '0};
      script[24] = '{1'b0, 4'd0, '{REQ_RUN,    8'hFF, 4'd0,  4'd0,  4'd0,  8'h00, 1'b0, 1'b1},
                    1'b1, '{8'hFF, 1'b0, 1'b1, 1'b1}};

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < 25; i++) begin
         if (script[i].cfg_before) load_start_state(script[i].cfg_val);
         send_word(script[i].w, script[i].typed, script[i].exp);
      end

      for (int p = 0; p < 4; p++) begin
         load_start_state(p == 0 ? 4'd15 : p == 1 ? 4'd0 : 4'($urandom_range(0, 15)));
         if (p == 0) begin
            // every edge defined before random words run
            for (int e = 0; e < 256; e++) begin
               fill = random_word();
               fill.kind = REQ_EDGE;
               fill.row = 4'(e >> 4);
               fill.col = 4'(e);
               send_word(fill, 1'b0, none);
            end
         end
         if (p == 1) hold_req = 1'b1;
         if (p == 3) calm = 1'b1;
         repeat (430) send_word(random_word(), 1'b0, none);
      end
      req_valid <= 1'b0;

      while (pending_translations.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_translations.size() == 0) begin
         $display("dfa_mealy_transducer test passed");
      end else begin
         $display("dfa_mealy_transducer test failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("dfa_mealy_transducer test failed");
      $finish;
   end

endmodule
